@@ hw/rtl/ljpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ljpf_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SIGMA   = 2'd0;
    localparam logic [1:0] CFG_EPSILON = 2'd1;
    localparam logic [1:0] CFG_CUTOFF  = 2'd2;

    localparam logic [23:0] SIGMA_RST   = 24'd151716;
    localparam logic [23:0] EPSILON_RST = 24'd10945;
    localparam logic [23:0] CUTOFF_RST  = 24'd393216;

    // Saturation ceiling of intermediate Q16.16 magnitudes
    localparam logic [40:0] CAP = 41'h100_0000_0000;

    // Stage map
    localparam int DIV_BITS = 41;
    localparam int ST_ABS   = 1;
    localparam int ST_SQ    = 2;
    localparam int ST_R2    = 3;
    localparam int ST_DIV0  = 4;
    localparam int ST_QK    = ST_DIV0 + DIV_BITS + 1;
    localparam int ST_M1    = ST_QK + 1;
    localparam int ST_M2    = ST_M1 + 3;
    localparam int ST_M3    = ST_M2 + 3;
    localparam int ST_T     = ST_M3 + 3;
    localparam int ST_M4    = ST_T + 1;
    localparam int ST_M5    = ST_M4 + 3;
    localparam int ST_OUT   = ST_M5 + 3;
    localparam int N_ST     = ST_OUT + 1;

    typedef logic [3:0][47:0] t_pp;

    typedef struct packed {
        logic [2:0][32:0] d;
        logic [2:0][23:0] ad;
        logic [2:0]       dneg;
        logic             far;
        logic [2:0][47:0] sq;
        logic [47:0]      sig2;
        logic [47:0]      cut2;
        logic [28:0]      eps24;
        logic [49:0]      r2;
        logic             inr;
        logic [63:0]      nq;
        logic [63:0]      nk;
        logic [90:0]      wq;
        logic [90:0]      wk;
        logic             ovq;
        logic             ovk;
        logic [40:0]      q;
        logic [40:0]      k;
        t_pp              pp;
        logic [83:0]      sum;
        logic [40:0]      m1;
        logic [40:0]      q3;
        logic [40:0]      q6;
        logic             tneg;
        logic [41:0]      tmag;
        logic [40:0]      fmag;
        t_pp [2:0]        fpp;
        logic [2:0][83:0] fsum;
        logic [2:0][40:0] fm;
        logic [2:0][31:0] force_v;
    } t_item;

    // 42x42 product as four partial products of at most 24x24
    function automatic t_pp mul_pp(input logic [41:0] a, input logic [41:0] b);
        t_pp p;
        p[0] = 48'(a[23:0]) * 48'(b[23:0]);
        p[1] = 48'(a[23:0]) * 48'(b[41:24]);
        p[2] = 48'(a[41:24]) * 48'(b[23:0]);
        p[3] = 48'(a[41:24]) * 48'(b[41:24]);
        return p;
    endfunction

    function automatic logic [83:0] mul_sum(input t_pp p);
        return 84'(p[0]) + (84'(p[1]) << 24) + (84'(p[2]) << 24) + (84'(p[3]) << 48);
    endfunction

    function automatic logic [40:0] mul_cap(input logic [83:0] s);
        logic [67:0] sh;
        sh = s[83:16];
        return (sh > 68'(CAP)) ? CAP : sh[40:0];
    endfunction

    // One restoring division step: w = {remainder, numerator bits, quotient bits}
    function automatic logic [90:0] div_step(input logic [90:0] w, input logic [49:0] den);
        logic [50:0] t;
        logic        ge;
        t  = w[90:40];
        ge = t >= {1'b0, den};
        if (ge) begin
            t = t - {1'b0, den};
        end
        return {t[49:0], w[39:0], ge};
    endfunction

    function automatic logic [40:0] div_final(input logic ov, input logic [90:0] w);
        return (ov || w[40:0] > CAP) ? CAP : w[40:0];
    endfunction

    function automatic t_item lj_stage(input int s, input t_item x, input logic [23:0] sig,
                                       input logic [23:0] eps, input logic [23:0] cut);
        t_item       y;
        logic [32:0] mag;
        logic [41:0] two_q6;
        logic [41:0] q3e;
        logic [40:0] m;
        logic [31:0] mm;
        logic        neg;
        y = x;
        if (s == ST_ABS) begin
            y.far = 1'b0;
            for (int c = 0; c < 3; c++) begin
                y.dneg[c] = x.d[c][32];
                mag = x.d[c][32] ? (~x.d[c] + 33'd1) : x.d[c];
                y.ad[c] = mag[23:0];
                if (mag > {9'd0, cut}) begin
                    y.far = 1'b1;
                end
            end
        end else if (s == ST_SQ) begin
            for (int c = 0; c < 3; c++) begin
                y.sq[c] = 48'(x.ad[c]) * 48'(x.ad[c]);
            end
            y.sig2  = 48'(sig) * 48'(sig);
            y.cut2  = 48'(cut) * 48'(cut);
            y.eps24 = (29'(eps) << 4) + (29'(eps) << 3);
        end else if (s == ST_R2) begin
            y.r2  = 50'(x.sq[0]) + 50'(x.sq[1]) + 50'(x.sq[2]);
            y.inr = !x.far && (y.r2 <= 50'(x.cut2));
            y.nq  = {x.sig2, 16'd0};
            y.nk  = {3'd0, x.eps24, 32'd0};
        end else if (s == ST_DIV0) begin
            y.wq  = {27'd0, x.nq};
            y.wk  = {27'd0, x.nk};
            y.ovq = {27'd0, x.nq[63:41]} >= x.r2;
            y.ovk = {27'd0, x.nk[63:41]} >= x.r2;
        end else if (s > ST_DIV0 && s < ST_QK) begin
            y.wq = div_step(x.wq, x.r2);
            y.wk = div_step(x.wk, x.r2);
        end else if (s == ST_QK) begin
            y.q = div_final(x.ovq, x.wq);
            y.k = div_final(x.ovk, x.wk);
        end else if (s == ST_M1) begin
            y.pp = mul_pp({1'b0, x.q}, {1'b0, x.q});
        end else if (s == ST_M2) begin
            y.pp = mul_pp({1'b0, x.m1}, {1'b0, x.q});
        end else if (s == ST_M3) begin
            y.pp = mul_pp({1'b0, x.q3}, {1'b0, x.q3});
        end else if (s == ST_M4) begin
            y.pp = mul_pp(x.tmag, {1'b0, x.k});
        end else if (s == ST_M1 + 1 || s == ST_M2 + 1 || s == ST_M3 + 1 || s == ST_M4 + 1) begin
            y.sum = mul_sum(x.pp);
        end else if (s == ST_M1 + 2) begin
            y.m1 = mul_cap(x.sum);
        end else if (s == ST_M2 + 2) begin
            y.q3 = mul_cap(x.sum);
        end else if (s == ST_M3 + 2) begin
            y.q6 = mul_cap(x.sum);
        end else if (s == ST_M4 + 2) begin
            y.fmag = mul_cap(x.sum);
        end else if (s == ST_T) begin
            two_q6 = {x.q6, 1'b0};
            q3e    = {1'b0, x.q3};
            y.tneg = two_q6 < q3e;
            y.tmag = y.tneg ? (q3e - two_q6) : (two_q6 - q3e);
        end else if (s == ST_M5) begin
            for (int c = 0; c < 3; c++) begin
                y.fpp[c] = mul_pp({1'b0, x.fmag}, {18'd0, x.ad[c]});
            end
        end else if (s == ST_M5 + 1) begin
            for (int c = 0; c < 3; c++) begin
                y.fsum[c] = mul_sum(x.fpp[c]);
            end
        end else if (s == ST_M5 + 2) begin
            for (int c = 0; c < 3; c++) begin
                y.fm[c] = mul_cap(x.fsum[c]);
            end
        end else if (s == ST_OUT) begin
            for (int c = 0; c < 3; c++) begin
                m   = x.fm[c];
                neg = x.tneg ^ x.dneg[c];
                if (!x.inr || m == 41'd0) begin
                    y.force_v[c] = 32'd0;
                end else if (neg) begin
                    mm = (m > 41'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
                    y.force_v[c] = ~mm + 32'd1;
                end else begin
                    y.force_v[c] = (m > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
                end
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lennard_jones_pair_force.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Lennard-Jones 12-6 pair force with cutoff, signed Q16.16. One atom pair per
// transfer on the input channel, one result per transfer on the output
// channel; the force is the one on the first atom (negate it for the second).
// The block accepts a new pair every cycle while no output stall backs up
// to the input. The depth is set by the two 41-stage restoring dividers
// (sigma^2/r^2 and 24*eps/r^2, one quotient bit per stage) and by the split
// 42x42 multiplies of three stages each. A stall on the output backs up
// through the stages; empty stages still fill, so the input keeps taking
// pairs until every stage holds one. Configuration registers may be written
// only while the pipeline is empty.
module lennard_jones_pair_force (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // configuration
    input  wire                i_cfg_we,
    input  wire         [1:0]  i_cfg_index,
    input  wire         [23:0] i_cfg_data,
    // input channel
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  signed [31:0] i_first_x,
    input  wire  signed [31:0] i_first_y,
    input  wire  signed [31:0] i_first_z,
    input  wire  signed [31:0] i_second_x,
    input  wire  signed [31:0] i_second_y,
    input  wire  signed [31:0] i_second_z,
    // output channel
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z,
    output logic               o_in_range
);
    import ljpf_pkg::*;

    // configuration registers
    logic [23:0] r_sigma;
    logic [23:0] r_eps;
    logic [23:0] r_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= SIGMA_RST;
            r_eps   <= EPSILON_RST;
            r_cut   <= CUTOFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIGMA:   r_sigma <= i_cfg_data;
                CFG_EPSILON: r_eps   <= i_cfg_data;
                CFG_CUTOFF:  r_cut   <= i_cfg_data;
                default: ;  // no register at this index
            endcase
        end
    end

    // pipeline: per-stage payload and valid bit
    t_item             r_st [N_ST];
    t_item             n_st [N_ST];
    logic [N_ST-1:0]   r_v;
    logic [N_ST-1:0]   load;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        load[N_ST-1] = !r_v[N_ST-1] || !i_out_stall;
        for (int s = N_ST - 2; s >= 0; s--) begin
            load[s] = !r_v[s] || load[s+1];
        end
    end

    assign o_in_stall = !load[0];

    always_comb begin
        // stage 0: separation vector, exact in 33 bits
        n_st[0]      = '0;
        n_st[0].d[0] = 33'(i_first_x) - 33'(i_second_x);
        n_st[0].d[1] = 33'(i_first_y) - 33'(i_second_y);
        n_st[0].d[2] = 33'(i_first_z) - 33'(i_second_z);
        for (int s = 1; s < N_ST; s++) begin
            n_st[s] = lj_stage(s, r_st[s-1], r_sigma, r_eps, r_cut);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (load[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int s = 1; s < N_ST; s++) begin
                if (load[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // payload carries no reset
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < N_ST; s++) begin
            if (load[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_out_valid = r_v[N_ST-1];
    assign o_force_x   = r_st[N_ST-1].force_v[0];
    assign o_force_y   = r_st[N_ST-1].force_v[1];
    assign o_force_z   = r_st[N_ST-1].force_v[2];
    assign o_in_range  = r_st[N_ST-1].inr;

endmodule

`default_nettype wire
